FILE: rtl/b2bcd_pkg.sv
// ----------------------------------------------------------------------------
// b2bcd_pkg
// Shared types, sizes, the double-dabble step and a digit check for the
// binary to packed BCD converter.
// ----------------------------------------------------------------------------
package b2bcd_pkg;

    localparam int BIN_W           = 32;
    localparam int DIGITS          = 10;
    localparam int BCD_W           = 4 * DIGITS;
    localparam int STEPS_PER_STAGE = 8;
    localparam int NUM_STAGES      = BIN_W / STEPS_PER_STAGE;
    localparam logic [3:0] DIGIT_MAX   = 4'd9;
    localparam logic [3:0] TOP_MAX     = 4'd4;

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [BCD_W-1:0] bcd;
    } conv_t;

    function automatic logic [BCD_W-1:0] dabble_step(
        input logic [BCD_W-1:0] bcd,
        input logic             bit_in
    );
        logic [BCD_W-1:0] adj;
        logic [3:0]       dig;
        adj = bcd;
        for (int d = 0; d < DIGITS; d++) begin
            dig = bcd[4*d +: 4];
            if (dig >= 4'd5)
            begin
                adj[4*d +: 4] = dig + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    function automatic logic bcd_ok(input logic [BCD_W-1:0] bcd);
        logic ok;
        ok = 1'b1;
        for (int d = 0; d < DIGITS; d++) begin
            if (bcd[4*d +: 4] > DIGIT_MAX)
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

FILE: rtl/b2bcd_if.sv
// ----------------------------------------------------------------------------
// b2bcd channel interfaces
// Valid/ready channels for the binary input word and the BCD result word.
// ----------------------------------------------------------------------------
interface b2bcd_in_if import b2bcd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [BIN_W-1:0] binary_value;

    modport source (output valid, output binary_value, input ready);
    modport sink   (input valid, input binary_value, output ready);
endinterface

interface b2bcd_out_if import b2bcd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [BCD_W-1:0] bcd_digits;

    modport source (output valid, output bcd_digits, input ready);
    modport sink   (input valid, input bcd_digits, output ready);
endinterface

FILE: rtl/b2bcd_stage.sv
// ----------------------------------------------------------------------------
// b2bcd_stage
// One pipeline stage: eight shift-and-add-3 steps followed by a register
// with its own valid bit and a ready chain for back pressure.
// ----------------------------------------------------------------------------
module b2bcd_stage
    import b2bcd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    output logic  up_ready,
    input  conv_t up_data,
    output logic  dn_valid,
    input  logic  dn_ready,
    output conv_t dn_data
);

    logic  valid_reg;
    logic  valid_next;
    conv_t data_reg;
    conv_t data_next;

    always_comb
    begin
        data_next = up_data;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            data_next.bcd = dabble_step(data_next.bcd, data_next.bin[BIN_W-1]);
            data_next.bin = {data_next.bin[BIN_W-2:0], 1'b0};
        end
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

FILE: rtl/binary_to_packed_bcd.sv
// ----------------------------------------------------------------------------
// binary_to_packed_bcd
// Converts an unsigned 32-bit word into ten packed BCD digits.
//
// The input channel carries one 32-bit binary word; the output channel
// returns one 40-bit word with the billions digit in bits 39..36 and the
// units digit in bits 3..0. Leading zeros are kept as zero nibbles.
// The conversion is shift-and-add-3 spread over four register stages of
// eight steps each; a word passes all four registers on its way out.
// A new word can be accepted every cycle unless the pipeline is stalled.
// Each stage has its own valid bit. When the receiver holds ready low,
// the result stays on the output and earlier stages keep filling until
// the pipeline is full; only then does the input ready drop. Nothing is
// dropped or repeated under stalls.
// Reset clears all valid bits; the pipeline comes out of reset empty and
// ready, and the data registers need no reset.
// ----------------------------------------------------------------------------
module binary_to_packed_bcd
    import b2bcd_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    b2bcd_in_if.sink     in_ch,
    b2bcd_out_if.source  out_ch
);

    logic  pipe_valid [NUM_STAGES+1];
    logic  pipe_ready [NUM_STAGES+1];
    conv_t pipe_data  [NUM_STAGES+1];

    assign pipe_valid[0]    = in_ch.valid;
    assign in_ch.ready      = pipe_ready[0];
    assign pipe_data[0].bin = in_ch.binary_value;
    assign pipe_data[0].bcd = '0;

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        b2bcd_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (pipe_valid[g]),
            .up_ready (pipe_ready[g]),
            .up_data  (pipe_data[g]),
            .dn_valid (pipe_valid[g+1]),
            .dn_ready (pipe_ready[g+1]),
            .dn_data  (pipe_data[g+1])
        );
    end

    assign out_ch.valid             = pipe_valid[NUM_STAGES];
    assign pipe_ready[NUM_STAGES]   = out_ch.ready;
    assign out_ch.bcd_digits        = pipe_data[NUM_STAGES].bcd;

    // Every delivered nibble is a decimal digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> bcd_ok(out_ch.bcd_digits))
        else $error("output word holds a nibble above nine");

    // A 32-bit value never has a billions digit above four.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.bcd_digits[BCD_W-1 -: 4] <= TOP_MAX))
        else $error("billions digit out of range");

    // The input is only held off when the pipeline is full up to the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
        else $error("input stalled while output is free");

endmodule
